/* hdl/mpd_pkg.sv */
// Shared types and constants for the median point depth block.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package mpd_pkg;

   localparam int unsigned MAX_POINTS_DEF = 256;
   localparam int unsigned DATA_W         = 32;
   localparam int unsigned COUNT_OUT_W    = 9;
   localparam int unsigned CSR_INDEX_W    = 2;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROW_X  = 2'd0,
      CSR_ROW_Y  = 2'd1,
      CSR_ROW_Z  = 2'd2,
      CSR_OFFSET = 2'd3
   } csr_index_type;

   localparam logic signed [DATA_W-1:0] ROW_X_RESET  = 32'sd0;
   localparam logic signed [DATA_W-1:0] ROW_Y_RESET  = 32'sd0;
   localparam logic signed [DATA_W-1:0] ROW_Z_RESET  = 32'sd1073741824;
   localparam logic signed [DATA_W-1:0] OFFSET_RESET = 32'sd0;

   // Command broadcast to every cell of the sorting chain.
   typedef struct packed {
      logic                     insert;
      logic                     shift;
      logic signed [DATA_W-1:0] key;
   } cell_cmd_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_MUL    = 6'b000010,
      ST_SUM    = 6'b000100,
      ST_SAT    = 6'b001000,
      ST_INSERT = 6'b010000,
      ST_DRAIN  = 6'b100000
   } state_type;

endpackage

/* hdl/mpd_if.sv */
// Valid/ready channel interfaces for point requests and median responses.
// Depends on mpd_pkg for the data and count widths.
`timescale 1ns / 1ps

interface mpd_req_if;
   import mpd_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] pos_x;
   logic signed [DATA_W-1:0] pos_y;
   logic signed [DATA_W-1:0] pos_z;
   logic                     last_point;

   modport source (output valid, pos_x, pos_y, pos_z, last_point, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, last_point, output ready);
endinterface

interface mpd_rsp_if;
   import mpd_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [DATA_W-1:0]      median_depth;
   logic        [COUNT_OUT_W-1:0] point_count;
   logic                          overflowed;

   modport source (output valid, median_depth, point_count, overflowed, input ready);
   modport sink   (input valid, median_depth, point_count, overflowed, output ready);
endinterface

/* hdl/mpd_depth.sv */
// Camera depth pipeline: three products, their sum, then rounding, offset and saturation.
// Depends on mpd_pkg. Three register stages, advancing on every clock.
`timescale 1ns / 1ps

module mpd_depth (
   input  logic                              clock,
   input  logic signed [mpd_pkg::DATA_W-1:0] row_x,
   input  logic signed [mpd_pkg::DATA_W-1:0] row_y,
   input  logic signed [mpd_pkg::DATA_W-1:0] row_z,
   input  logic signed [mpd_pkg::DATA_W-1:0] offset,
   input  logic signed [mpd_pkg::DATA_W-1:0] pos_x,
   input  logic signed [mpd_pkg::DATA_W-1:0] pos_y,
   input  logic signed [mpd_pkg::DATA_W-1:0] pos_z,
   output logic signed [mpd_pkg::DATA_W-1:0] depth
);
   import mpd_pkg::*;

   localparam int unsigned PROD_W  = 2 * DATA_W;
   localparam int unsigned SUM_W   = PROD_W + 2;
   localparam int unsigned FRAC_W  = 30;
   localparam int unsigned ROUND_W = SUM_W - FRAC_W;
   localparam int unsigned TOT_W   = ROUND_W + 1;

   logic signed [PROD_W-1:0]  prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [SUM_W-1:0]   sum_in;
   logic signed [SUM_W-1:0]   biased;
   logic signed [ROUND_W-1:0] rounded;
   logic signed [TOT_W-1:0]   total;
   logic signed [DATA_W-1:0]  depth_ff;
   logic signed [DATA_W-1:0]  depth_in;

   localparam logic signed [TOT_W-1:0] SAT_HI = TOT_W'(64'sh7FFF_FFFF);
   localparam logic signed [TOT_W-1:0] SAT_LO = -TOT_W'(64'sh8000_0000);

   assign sum_in = SUM_W'(prod_x_ff) + SUM_W'(prod_y_ff) + SUM_W'(prod_z_ff);

   // Round half toward plus infinity, then drop the thirty fraction bits.
   always_comb begin
      biased  = sum_ff + (SUM_W'(1) <<< (FRAC_W - 1));
      rounded = ROUND_W'(biased >>> FRAC_W);
      total   = TOT_W'(rounded) + TOT_W'(offset);
      if (total > SAT_HI) begin
         depth_in = DATA_W'(SAT_HI);
      end else if (total < SAT_LO) begin
         depth_in = DATA_W'(SAT_LO);
      end else begin
         depth_in = DATA_W'(total);
      end
   end

   always_ff @(posedge clock) begin
      prod_x_ff <= PROD_W'(row_x) * PROD_W'(pos_x);
      prod_y_ff <= PROD_W'(row_y) * PROD_W'(pos_y);
      prod_z_ff <= PROD_W'(row_z) * PROD_W'(pos_z);
      sum_ff    <= sum_in;
      depth_ff  <= depth_in;
   end

   assign depth = depth_ff;

endmodule

/* hdl/mpd_cell.sv */
// One cell of the sorting chain: holds one depth, inserts or shifts with its neighbors.
// Depends on mpd_pkg for the command struct.
`timescale 1ns / 1ps

module mpd_cell (
   input  logic                              clock,
   input  mpd_pkg::cell_cmd_type             cmd,
   input  logic                              occupied,
   input  logic                              prev_le,
   input  logic signed [mpd_pkg::DATA_W-1:0] prev_value,
   input  logic signed [mpd_pkg::DATA_W-1:0] next_value,
   output logic signed [mpd_pkg::DATA_W-1:0] value,
   output logic                              le
);
   import mpd_pkg::*;

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;

   // A held value not above the key stays; the first cell past those takes the key,
   // and the cells after it take their left neighbor's value.
   assign le = occupied && (value_ff <= cmd.key);

   always_comb begin
      value_in = value_ff;
      if (cmd.insert) begin
         if (le) begin
            value_in = value_ff;
         end else if (prev_le) begin
            value_in = cmd.key;
         end else begin
            value_in = prev_value;
         end
      end else if (cmd.shift) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

/* hdl/median_point_depth_unit.sv */
// Median point depth unit: computes point depths and reports the median of each set.
// A point is accepted in the idle state and passes the multiply, sum and saturate states
// before it is inserted; the next point is taken only back in idle, so one at a time.
// A point marked last then has the sorting chain shift the median to its head; the response
// is loaded once the previous one is taken. Reset is synchronous: it clears the set,
// the response valid and the registers to their defaults; chain contents stay unknown.
`timescale 1ns / 1ps

module median_point_depth_unit #(
   parameter int unsigned MAX_POINTS = mpd_pkg::MAX_POINTS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   mpd_req_if.sink                                req_chan,
   mpd_rsp_if.source                              rsp_chan,
   input  logic                                   csr_we,
   input  logic [mpd_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [mpd_pkg::DATA_W-1:0]             csr_wdata
);
   import mpd_pkg::*;

   localparam int unsigned CW = $clog2(MAX_POINTS + 1);

   state_type state_ff, state_in;

   logic signed [DATA_W-1:0] row_x_ff, row_y_ff, row_z_ff, offset_ff;
   logic signed [DATA_W-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic                     last_ff;
   logic [CW-1:0]            count_ff, count_in;
   logic                     drop_ff, drop_in;
   logic [CW-1:0]            drain_ff, drain_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_depth_ff;
   logic [COUNT_OUT_W-1:0]   rsp_count_ff;
   logic                     rsp_ovf_ff;
   logic                     load_rsp;

   logic signed [DATA_W-1:0] depth;
   cell_cmd_type             cmd;
   logic signed [DATA_W-1:0] cell_value [MAX_POINTS];
   logic                     cell_le    [MAX_POINTS];
   logic                     full;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign full           = (count_ff == CW'(MAX_POINTS));

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_x_ff  <= ROW_X_RESET;
         row_y_ff  <= ROW_Y_RESET;
         row_z_ff  <= ROW_Z_RESET;
         offset_ff <= OFFSET_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROW_X:  row_x_ff  <= csr_wdata;
            CSR_ROW_Y:  row_y_ff  <= csr_wdata;
            CSR_ROW_Z:  row_z_ff  <= csr_wdata;
            CSR_OFFSET: offset_ff <= csr_wdata;
            default:    row_x_ff  <= row_x_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         pos_x_ff <= req_chan.pos_x;
         pos_y_ff <= req_chan.pos_y;
         pos_z_ff <= req_chan.pos_z;
         last_ff  <= req_chan.last_point;
      end
   end

   mpd_depth u_depth (
      .clock  (clock),
      .row_x  (row_x_ff),
      .row_y  (row_y_ff),
      .row_z  (row_z_ff),
      .offset (offset_ff),
      .pos_x  (pos_x_ff),
      .pos_y  (pos_y_ff),
      .pos_z  (pos_z_ff),
      .depth  (depth)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      drain_in     = drain_ff;
      load_rsp     = 1'b0;
      cmd.insert   = 1'b0;
      cmd.shift    = 1'b0;
      cmd.key      = depth;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_SAT;
         ST_SAT:  state_in = ST_INSERT;
         ST_INSERT: begin
            if (full) begin
               drop_in = 1'b1;
            end else begin
               cmd.insert = 1'b1;
               count_in   = count_ff + CW'(1);
            end
            drain_in = count_in >> 1;
            state_in = last_ff ? ST_DRAIN : ST_IDLE;
         end
         ST_DRAIN: begin
            if (drain_ff != '0) begin
               cmd.shift = 1'b1;
               drain_in  = drain_ff - CW'(1);
            end else if (!rsp_valid_ff || rsp_chan.ready) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               count_in     = '0;
               drop_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_depth_ff <= cell_value[0];
         rsp_count_ff <= COUNT_OUT_W'(count_ff);
         rsp_ovf_ff   <= drop_ff;
      end
   end

   // Sorting chain, ascending from cell zero.
   for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
      logic                     occupied;
      logic                     prev_le;
      logic signed [DATA_W-1:0] prev_value;
      logic signed [DATA_W-1:0] next_value;

      assign occupied = (CW'(i) < count_ff);

      if (i == 0) begin : g_head
         assign prev_le    = 1'b1;
         assign prev_value = depth;
      end else begin : g_body
         assign prev_le    = cell_le[i-1];
         assign prev_value = cell_value[i-1];
      end

      if (i == MAX_POINTS - 1) begin : g_tail
         assign next_value = cell_value[i];
      end else begin : g_inner
         assign next_value = cell_value[i+1];
      end

      mpd_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .occupied   (occupied),
         .prev_le    (prev_le),
         .prev_value (prev_value),
         .next_value (next_value),
         .value      (cell_value[i]),
         .le         (cell_le[i])
      );
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.median_depth = rsp_depth_ff;
   assign rsp_chan.point_count  = rsp_count_ff;
   assign rsp_chan.overflowed   = rsp_ovf_ff;

endmodule
